// ===== src/i2cbb_pkg.sv =====
`timescale 1ns / 1ps

package i2cbb_pkg;

    // Action codes on the request channel
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Item kind after classification
    typedef enum logic [1:0] {
        K_TICK,
        K_WRITE,
        K_READ,
        K_NONE
    } t_kind;

    // Byte sub-steps
    localparam logic [4:0] STEP_ACK_RELEASE = 5'd16;
    localparam logic [4:0] STEP_ACK_CLOCK   = 5'd17;
    localparam logic [4:0] STEP_ACK_SAMPLE  = 5'd18;
    localparam logic [4:0] STEP_LAST        = 5'd19;

    localparam logic [7:0] READ_BIT       = 8'h01;
    localparam logic [2:0] WRITE_DATA_MAX = 3'd2;
    localparam logic [2:0] ADDR_BYTES     = 3'd2;

    // Transmit store slots: address, register, two data bytes
    localparam int STORE_SLOTS = 4;
    localparam int SLOT_DEV    = 0;
    localparam int SLOT_REG    = 1;
    localparam int SLOT_DATA0  = 2;
    localparam int SLOT_DATA1  = 3;

    // Queue between front and engine
    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        t_kind       kind;
        logic        sda_in;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [2:0]  write_total;
        logic [2:0]  read_total;
    } t_item;

endpackage

// ===== src/i2cbb_if.sv =====
`timescale 1ns / 1ps

interface i2cbb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       sda_in;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic [2:0] byte_count;

    modport source (
        output valid, action, sda_in, dev_addr, reg_addr, data_first, data_second,
               byte_count,
        input  ready
    );
    modport sink (
        input  valid, action, sda_in, dev_addr, reg_addr, data_first, data_second,
               byte_count,
        output ready
    );
endinterface

interface i2cbb_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [1:0] byte_index;
    logic       nack_seen;

    modport source (
        output valid, scl_level, sda_level, busy_res, byte_valid, byte_value, byte_index,
               nack_seen,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_level, busy_res, byte_valid, byte_value, byte_index,
               nack_seen,
        output ready
    );
endinterface

// ===== src/i2cbb_front.sv =====
`timescale 1ns / 1ps

module i2cbb_front #(
    parameter int MAX_BYTES = 4
) (
    i2cbb_in_if.sink         i_in,
    input  logic             i_full,
    output logic             o_push,
    output i2cbb_pkg::t_item o_item
);
    import i2cbb_pkg::*;

    logic [2:0] w_wdata;
    logic [2:0] w_wsum;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        case (i_in.action)
            ACT_TICK:  o_item.kind = K_TICK;
            ACT_WRITE: o_item.kind = K_WRITE;
            ACT_READ:  o_item.kind = K_READ;
            default:   o_item.kind = K_NONE;
        endcase

        o_item.sda_in      = i_in.sda_in;
        o_item.dev_addr    = i_in.dev_addr;
        o_item.reg_addr    = i_in.reg_addr;
        o_item.data_first  = i_in.data_first;
        o_item.data_second = i_in.data_second;

        // write: address + register + up to two payload bytes
        w_wdata = (i_in.byte_count > WRITE_DATA_MAX) ? WRITE_DATA_MAX : i_in.byte_count;
        w_wsum  = ADDR_BYTES + w_wdata;
        if (int'(w_wsum) > MAX_BYTES) begin
            o_item.write_total = 3'(MAX_BYTES);
        end else begin
            o_item.write_total = w_wsum;
        end

        if (int'(i_in.byte_count) > MAX_BYTES) begin
            o_item.read_total = 3'(MAX_BYTES);
        end else begin
            o_item.read_total = i_in.byte_count;
        end
    end

endmodule

// ===== src/i2cbb_fifo.sv =====
`timescale 1ns / 1ps

module i2cbb_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  i2cbb_pkg::t_item i_data,
    output logic             o_full,
    input  logic             i_pop,
    output i2cbb_pkg::t_item o_data,
    output logic             o_empty
);
    import i2cbb_pkg::*;

    t_item             r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wptr;
    logic [FPTR_W-1:0] r_rptr;
    logic [FCNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == FCNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    function automatic logic [FPTR_W-1:0] ptr_inc(input logic [FPTR_W-1:0] ptr);
        if (ptr == FPTR_W'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return ptr + FPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (w_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + FCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - FCNT_W'(1);
            end
        end
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== src/i2cbb_engine.sv =====
`timescale 1ns / 1ps

module i2cbb_engine #(
    parameter int MAX_BYTES = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  i2cbb_pkg::t_item i_item,
    input  logic             i_empty,
    output logic             o_pop,
    i2cbb_out_if.source      o_out
);
    import i2cbb_pkg::*;

    localparam int STORE_DEPTH = (MAX_BYTES < STORE_SLOTS) ? MAX_BYTES : STORE_SLOTS;
    localparam int SIDX_W      = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_WRITE,
        PH_READ,
        PH_END
    } t_phase;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [4:0] step;
        logic       nack;
        logic [7:0] shift;
    } t_sub;

    t_phase     r_phase, n_phase;
    logic [4:0] r_step, n_step;
    logic [2:0] r_wofs, n_wofs;
    logic [2:0] r_wtot, n_wtot;
    logic [3:0] r_rofs, n_rofs;
    logic [2:0] r_rtot, n_rtot;
    logic [7:0] r_shift, n_shift;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [7:0] r_store [STORE_DEPTH];

    logic       r_out_valid;
    logic       r_bvalid, n_bvalid;
    logic [7:0] r_bvalue, n_bvalue;
    logic [1:0] r_bindex, n_bindex;
    logic       r_nack, n_nack;

    logic       w_load;
    t_sub       w_sub;
    logic [3:0] w_rofs_m1;

    // Transmit sub-step: 8 data bits, then release, clock and sample the ACK
    function automatic t_sub tx_sub(input logic [4:0] step_v, input logic [7:0] byte_v,
                                    input logic sda_in, input logic scl_v, input logic sda_v);
        t_sub       res;
        logic [2:0] bsel;
        res.scl   = scl_v;
        res.sda   = sda_v;
        res.step  = step_v + 5'd1;
        res.nack  = 1'b0;
        res.shift = byte_v;
        bsel      = 3'd7 - step_v[3:1];
        if (step_v < STEP_ACK_RELEASE) begin
            if (!step_v[0]) begin
                res.scl = 1'b0;
                res.sda = byte_v[bsel];
            end else begin
                res.scl = 1'b1;
            end
        end else if (step_v == STEP_ACK_RELEASE) begin
            res.scl = 1'b0;
            res.sda = 1'b1;
        end else if (step_v == STEP_ACK_CLOCK) begin
            res.scl = 1'b1;
        end else if (step_v == STEP_ACK_SAMPLE) begin
            res.nack = sda_in;
            res.scl  = 1'b0;
        end else begin
            res.sda  = 1'b0;
            res.step = '0;
        end
        return res;
    endfunction

    // Receive sub-step: 8 bits shifted in on falling SCL, then ACK or NACK
    function automatic t_sub rx_sub(input logic [4:0] step_v, input logic [7:0] shift_v,
                                    input logic sda_in, input logic give_ack,
                                    input logic scl_v, input logic sda_v);
        t_sub res;
        res.scl   = scl_v;
        res.sda   = sda_v;
        res.step  = step_v + 5'd1;
        res.nack  = 1'b0;
        res.shift = shift_v;
        if (step_v < STEP_ACK_RELEASE) begin
            if (!step_v[0]) begin
                res.sda = 1'b1;
                res.scl = 1'b1;
            end else begin
                res.shift = {shift_v[6:0], sda_in};
                res.scl   = 1'b0;
            end
        end else if (step_v == STEP_ACK_RELEASE) begin
            res.sda = !give_ack;
        end else if (step_v == STEP_ACK_CLOCK) begin
            res.scl = 1'b1;
        end else if (step_v == STEP_ACK_SAMPLE) begin
            res.scl = 1'b0;
            res.sda = 1'b1;
        end else begin
            res.sda  = 1'b0;
            res.step = '0;
        end
        return res;
    endfunction

    function automatic logic [7:0] slot_byte(input int idx, input t_item it,
                                             input logic [7:0] old_v);
        logic [7:0] res;
        res = old_v;
        case (idx)
            SLOT_DEV:   res = {it.dev_addr, 1'b0};
            SLOT_REG:   res = it.reg_addr;
            SLOT_DATA0: res = (it.kind == K_WRITE) ? it.data_first : old_v;
            SLOT_DATA1: res = (it.kind == K_WRITE) ? it.data_second : old_v;
            default:    res = old_v;
        endcase
        return res;
    endfunction

    // Engine advances only when the result slot is free or being emptied
    assign o_pop = !i_empty && (!r_out_valid || o_out.ready);

    assign w_rofs_m1 = r_rofs - 4'd1;

    always_comb begin
        n_phase  = r_phase;
        n_step   = r_step;
        n_wofs   = r_wofs;
        n_wtot   = r_wtot;
        n_rofs   = r_rofs;
        n_rtot   = r_rtot;
        n_shift  = r_shift;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_bvalid = 1'b0;
        n_bvalue = '0;
        n_bindex = '0;
        n_nack   = 1'b0;
        w_load   = 1'b0;
        w_sub    = '0;

        case (i_item.kind)
            K_WRITE, K_READ: begin
                if (r_phase == PH_IDLE) begin
                    w_load  = 1'b1;
                    n_step  = '0;
                    n_wofs  = '0;
                    n_rofs  = '0;
                    n_phase = PH_START;
                    if (i_item.kind == K_WRITE) begin
                        n_wtot = i_item.write_total;
                        n_rtot = '0;
                    end else begin
                        n_wtot = ADDR_BYTES;
                        n_rtot = i_item.read_total;
                    end
                end
            end
            K_TICK: begin
                case (r_phase)
                    PH_START: begin
                        if (r_step == '0) begin
                            n_sda  = 1'b0;
                            n_step = 5'd1;
                        end else begin
                            n_scl  = 1'b0;
                            n_step = '0;
                            if (r_wofs < r_wtot) begin
                                n_phase = PH_WRITE;
                            end else if (r_rtot != '0) begin
                                n_phase = PH_READ;
                            end else begin
                                n_phase = PH_END;
                            end
                        end
                    end
                    PH_WRITE: begin
                        w_sub   = tx_sub(r_step, r_store[r_wofs[SIDX_W-1:0]], i_item.sda_in,
                                         r_scl, r_sda);
                        n_scl   = w_sub.scl;
                        n_sda   = w_sub.sda;
                        n_step  = w_sub.step;
                        n_shift = w_sub.shift;
                        n_nack  = w_sub.nack;
                        if (w_sub.step == '0) begin
                            n_wofs = r_wofs + 3'd1;
                            if (n_wofs >= r_wtot) begin
                                n_phase = PH_END;
                            end
                        end
                    end
                    PH_READ: begin
                        if (r_rofs == '0) begin
                            w_sub = tx_sub(r_step, r_store[0] | READ_BIT, i_item.sda_in,
                                           r_scl, r_sda);
                        end else begin
                            w_sub = rx_sub(r_step, r_shift, i_item.sda_in,
                                           r_rofs < {1'b0, r_rtot}, r_scl, r_sda);
                        end
                        n_scl   = w_sub.scl;
                        n_sda   = w_sub.sda;
                        n_step  = w_sub.step;
                        n_shift = w_sub.shift;
                        n_nack  = w_sub.nack;
                        if (w_sub.step == '0) begin
                            if (r_rofs != '0) begin
                                n_bvalid = 1'b1;
                                n_bvalue = w_sub.shift;
                                n_bindex = w_rofs_m1[1:0];
                            end
                            n_rofs = r_rofs + 4'd1;
                            if (n_rofs > {1'b0, r_rtot}) begin
                                n_phase = PH_END;
                            end
                        end
                    end
                    PH_END: begin
                        if (r_step == '0) begin
                            n_scl  = 1'b1;
                            n_step = 5'd1;
                        end else begin
                            n_sda  = 1'b1;
                            n_step = '0;
                            if (r_rtot != '0 && r_rofs <= {1'b0, r_rtot}) begin
                                n_phase = PH_START;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_step      <= '0;
            r_wofs      <= '0;
            r_wtot      <= '0;
            r_rofs      <= '0;
            r_rtot      <= '0;
            r_shift     <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_step      <= n_step;
                r_wofs      <= n_wofs;
                r_wtot      <= n_wtot;
                r_rofs      <= n_rofs;
                r_rtot      <= n_rtot;
                r_shift     <= n_shift;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_bvalid <= n_bvalid;
            r_bvalue <= n_bvalue;
            r_bindex <= n_bindex;
            r_nack   <= n_nack;
        end
        if (o_pop && w_load) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= slot_byte(i, i_item, r_store[i]);
            end
        end
    end

    // Line state only moves on a pop, so it is the state after the shown result
    assign o_out.valid      = r_out_valid;
    assign o_out.scl_level  = r_scl;
    assign o_out.sda_level  = r_sda;
    assign o_out.busy_res   = (r_phase != PH_IDLE);
    assign o_out.byte_valid = r_bvalid;
    assign o_out.byte_value = r_bvalue;
    assign o_out.byte_index = r_bindex;
    assign o_out.nack_seen  = r_nack;

`ifndef NO_ASSERTIONS
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_scl && r_sda)
        else $error("bus not released while idle");

    a_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_bvalid |-> r_phase != PH_IDLE)
        else $error("received byte reported outside a transfer");

    a_wofs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wofs <= r_wtot)
        else $error("write offset past write total");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped item produced no result");

    a_hold_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> $stable(r_phase) && $stable(r_step))
        else $error("engine state moved without a pop");
`endif

endmodule

// ===== src/i2c_bitbang_master.sv =====
// Tick-driven bit-banged I2C master.
// Input channel i_in (valid/ready): each transfer carries an action (tick, write
// request, read request) with the sampled SDA level and the request fields.
// Output channel o_out (valid/ready): exactly one result transfer per input
// transfer, in order, giving the driven SCL/SDA levels, busy, any received
// byte with its index, and the sampled slave NACK.
// A request is loaded only while idle; otherwise it counts as nothing. While
// busy, every tick moves the bus by one half bit.
// Path: the item is written to the front queue at the accepting edge and is
// popped into the engine's result register once that register is free or
// being emptied.
// Throughput: one item per cycle while o_out.ready stays high, set by the engine,
// which retires one queue entry per cycle into its single result register.
// Stall: when o_out.ready is low the result holds and the engine stops; the
// two-entry queue fills and then i_in.ready drops. No item is lost.
// Reset (i_rst_n low, synchronous): engine idle, SCL and SDA released high,
// queue and result register empty.
`timescale 1ns / 1ps

module i2c_bitbang_master #(
    parameter int MAX_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cbb_in_if.sink    i_in,
    i2cbb_out_if.source o_out
);
    import i2cbb_pkg::*;

    t_item w_push_item;
    t_item w_pop_item;
    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;

    // front: decode action, clip counts
    i2cbb_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_item (w_push_item)
    );

    // short queue decoupling input acceptance from the bus engine
    i2cbb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_item),
        .o_empty (w_empty)
    );

    // back: phase/step sequencer driving SCL and SDA
    i2cbb_engine #(
        .MAX_BYTES (MAX_BYTES)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_pop_item),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import i2cbb_pkg::*;

    localparam logic [1:0] ACT_RSVD   = 2'd3;     // undefined action, must be ignored
    localparam logic [2:0] RD_MAX     = 3'd4;     // MAX_BYTES of the instance
    localparam int         RAND_ITEMS = 80;
    localparam int         RUN_OUT    = 0;        // row repeat: tick until the bus goes idle
    localparam int         IDLE_PCT   = 8;
    localparam int         QUIET_LO   = 200;      // no idling on either side in this window
    localparam int         QUIET_HI   = 320;
    localparam int         HOLD_AT    = 150;      // result count that starts the long stall
    localparam int         HOLD_CYC   = 64;
    localparam int         DRAIN_CYC  = 20;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PRINT_CAP  = 40;

    // {scl, sda, busy} for rows whose result is typed in
    localparam logic [2:0] LINE_IDLE   = 3'b110;
    localparam logic [2:0] LINE_LOADED = 3'b111;
    localparam logic [2:0] LINE_NONE   = 3'b000;

    typedef enum logic [2:0] {
        BUS_IDLE,
        BUS_START,
        BUS_SEND,
        BUS_RECV,
        BUS_STOP
    } t_bus_phase;

    typedef struct packed {
        logic [1:0] action;
        logic       sda_in;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] data_first;
        logic [7:0] data_second;
        logic [2:0] byte_count;
    } t_req;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [1:0] byte_index;
        logic       nack_seen;
    } t_resp;

    typedef struct packed {
        t_req       req;
        int         reps;
        bit         rnd_sda;
        bit         typed;
        logic [2:0] line;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    i2cbb_in_if  in_bus ();
    i2cbb_out_if out_bus ();

    i2c_bitbang_master #(.MAX_BYTES(RD_MAX)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------- bus master state, mirrored ----------------
    t_bus_phase ph;
    logic [4:0] st;
    logic [2:0] wr_ofs;
    logic [2:0] wr_tot;
    logic [2:0] rd_ofs;
    logic [2:0] rd_tot;
    logic [7:0] shreg;
    logic [7:0] tx_store [STORE_SLOTS];
    logic       scl_q;
    logic       sda_q;

    t_resp pending [$];

    int in_accepted;
    int results_seen;
    int mismatches;
    int cycles;
    int n_writes;
    int n_reads;
    int n_ignored;
    int n_bytes_rx;
    int n_nacks;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] result %0d %s: got %0h want %0h", $time, results_seen, what, got,
                     want);
        mismatches++;
    endtask

    // One half bit of a transmitted byte; returns the sampled NACK.
    function automatic logic tx_half(input logic sda_in);
        logic nack;
        nack = 1'b0;
        if (st == STEP_LAST) begin
            sda_q = 1'b0;
            st    = '0;
        end else begin
            if (st < STEP_ACK_RELEASE) begin
                if (!st[0]) begin
                    scl_q = 1'b0;
                    sda_q = shreg[3'd7 - st[3:1]];
                end else begin
                    scl_q = 1'b1;
                end
            end else if (st == STEP_ACK_RELEASE) begin
                scl_q = 1'b0;
                sda_q = 1'b1;
            end else if (st == STEP_ACK_CLOCK) begin
                scl_q = 1'b1;
            end else begin
                nack  = sda_in;
                scl_q = 1'b0;
            end
            st = st + 5'd1;
        end
        return nack;
    endfunction

    // One half bit of a received byte; master ACKs unless this is the last byte.
    function automatic void rx_half(input logic sda_in, input logic give_ack);
        if (st == STEP_LAST) begin
            sda_q = 1'b0;
            st    = '0;
        end else begin
            if (st < STEP_ACK_RELEASE) begin
                if (!st[0]) begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                end else begin
                    shreg = {shreg[6:0], sda_in};
                    scl_q = 1'b0;
                end
            end else if (st == STEP_ACK_RELEASE) begin
                sda_q = ~give_ack;
            end else if (st == STEP_ACK_CLOCK) begin
                scl_q = 1'b1;
            end else begin
                scl_q = 1'b0;
                sda_q = 1'b1;
            end
            st = st + 5'd1;
        end
    endfunction

    // Advance the mirrored master by one accepted item and give its result.
    function automatic t_resp i2c_line_predict(input t_req r);
        t_resp      o;
        logic [2:0] n_data;
        logic [2:0] idx;
        o = '0;
        case (r.action)
            ACT_WRITE, ACT_READ: begin
                if (ph == BUS_IDLE) begin
                    st     = '0;
                    wr_ofs = '0;
                    rd_ofs = '0;
                    tx_store[SLOT_DEV] = {r.dev_addr, 1'b0};
                    tx_store[SLOT_REG] = r.reg_addr;
                    if (r.action == ACT_WRITE) begin
                        n_data = (r.byte_count > WRITE_DATA_MAX) ? WRITE_DATA_MAX : r.byte_count;
                        wr_tot = ADDR_BYTES + n_data;
                        if (wr_tot > RD_MAX)
                            wr_tot = RD_MAX;
                        tx_store[SLOT_DATA0] = r.data_first;
                        tx_store[SLOT_DATA1] = r.data_second;
                        rd_tot = '0;
                    end else begin
                        wr_tot = ADDR_BYTES;
                        rd_tot = (r.byte_count > RD_MAX) ? RD_MAX : r.byte_count;
                    end
                    ph = BUS_START;
                end
            end
            ACT_TICK: begin
                case (ph)
                    BUS_START: begin
                        if (st == '0) begin
                            sda_q = 1'b0;
                            st    = 5'd1;
                        end else begin
                            scl_q = 1'b0;
                            st    = '0;
                            if (wr_ofs < wr_tot)
                                ph = BUS_SEND;
                            else if (rd_tot != '0)
                                ph = BUS_RECV;
                            else
                                ph = BUS_STOP;
                        end
                    end
                    BUS_SEND: begin
                        shreg = (wr_ofs < STORE_SLOTS) ? tx_store[wr_ofs] : 8'h00;
                        o.nack_seen = tx_half(r.sda_in);
                        if (st == '0) begin
                            wr_ofs = wr_ofs + 3'd1;
                            if (wr_ofs >= wr_tot)
                                ph = BUS_STOP;
                        end
                    end
                    BUS_RECV: begin
                        // first byte of the read phase is the address with the read bit
                        if (rd_ofs == '0) begin
                            shreg = tx_store[SLOT_DEV] | READ_BIT;
                            o.nack_seen = tx_half(r.sda_in);
                        end else begin
                            rx_half(r.sda_in, rd_ofs < rd_tot);
                        end
                        if (st == '0) begin
                            if (rd_ofs != '0) begin
                                idx          = rd_ofs - 3'd1;
                                o.byte_valid = 1'b1;
                                o.byte_value = shreg;
                                o.byte_index = idx[1:0];
                            end
                            rd_ofs = rd_ofs + 3'd1;
                            if (rd_ofs > rd_tot)
                                ph = BUS_STOP;
                        end
                    end
                    BUS_STOP: begin
                        if (st == '0) begin
                            scl_q = 1'b1;
                            st    = 5'd1;
                        end else begin
                            sda_q = 1'b1;
                            st    = '0;
                            // a read with data still to fetch goes on with a repeated START
                            if (rd_tot != '0 && rd_ofs <= rd_tot)
                                ph = BUS_START;
                            else
                                ph = BUS_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        o.scl_level = scl_q;
        o.sda_level = sda_q;
        o.busy_res  = (ph != BUS_IDLE);
        return o;
    endfunction

    function automatic t_req rand_req(input logic [1:0] act);
        t_req r;
        r.action      = act;
        r.sda_in      = $urandom_range(1);
        r.dev_addr    = $urandom_range(127);
        r.reg_addr    = $urandom_range(255);
        r.data_first  = $urandom_range(255);
        r.data_second = $urandom_range(255);
        r.byte_count  = $urandom_range(7);
        return r;
    endfunction

    function automatic t_row mk_row(input logic [1:0] act, input logic sda,
                                    input logic [6:0] dev, input logic [7:0] ra,
                                    input logic [7:0] d0, input logic [7:0] d1,
                                    input logic [2:0] cnt, input int reps, input bit rnd,
                                    input bit typed, input logic [2:0] line);
        t_row w;
        w.req     = '{act, sda, dev, ra, d0, d1, cnt};
        w.reps    = reps;
        w.rnd_sda = rnd;
        w.typed   = typed;
        w.line    = line;
        return w;
    endfunction

    // Offer one item, wait for the transfer, then record what must come back.
    task automatic put_item(input t_req r, input bit typed, input logic [2:0] line);
        t_resp want;
        bit    quiet;
        @(negedge i_clk);
        quiet = (in_accepted >= QUIET_LO && in_accepted < QUIET_HI);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        in_bus.action      = r.action;
        in_bus.sda_in      = r.sda_in;
        in_bus.dev_addr    = r.dev_addr;
        in_bus.reg_addr    = r.reg_addr;
        in_bus.data_first  = r.data_first;
        in_bus.data_second = r.data_second;
        in_bus.byte_count  = r.byte_count;
        in_bus.valid       = 1'b1;
        @(posedge i_clk);
        while (!in_bus.ready)
            @(posedge i_clk);

        if (r.action == ACT_RSVD || (r.action != ACT_TICK && ph != BUS_IDLE))
            n_ignored++;
        else if (r.action == ACT_WRITE)
            n_writes++;
        else if (r.action == ACT_READ)
            n_reads++;

        want = i2c_line_predict(r);
        n_bytes_rx += want.byte_valid;
        n_nacks    += want.nack_seen;
        if (typed) begin
            want = '0;
            {want.scl_level, want.sda_level, want.busy_res} = line;
        end
        pending.push_back(want);
        in_accepted++;
    endtask

    // ---------------- result side ----------------
    initial begin
        bit hold_done;
        bit quiet;
        hold_done     = 1'b0;
        out_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                // long back-pressure: the input queue must fill and stall
                out_bus.ready = 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_done = 1'b1;
            end
            quiet = (results_seen >= QUIET_LO && results_seen < QUIET_HI);
            out_bus.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_resp got;
        t_resp want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got = '{out_bus.scl_level, out_bus.sda_level, out_bus.busy_res, out_bus.byte_valid,
                    out_bus.byte_value, out_bus.byte_index, out_bus.nack_seen};
            if (pending.size() == 0) begin
                report_mismatch("transfer with nothing pending", got, 0);
            end else begin
                want = pending.pop_front();
                if (got.scl_level !== want.scl_level)
                    report_mismatch("scl_level", got.scl_level, want.scl_level);
                if (got.sda_level !== want.sda_level)
                    report_mismatch("sda_level", got.sda_level, want.sda_level);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", got.busy_res, want.busy_res);
                if (got.byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
                if (got.byte_value !== want.byte_value)
                    report_mismatch("byte_value", got.byte_value, want.byte_value);
                if (got.byte_index !== want.byte_index)
                    report_mismatch("byte_index", got.byte_index, want.byte_index);
                if (got.nack_seen !== want.nack_seen)
                    report_mismatch("nack_seen", got.nack_seen, want.nack_seen);
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("i2c_bitbang_master verification failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        t_row plan [$];
        t_row w;
        t_req r;
        int   rnd_done;

        in_accepted  = 0;
        results_seen = 0;
        mismatches   = 0;
        cycles       = 0;
        n_writes     = 0;
        n_reads      = 0;
        n_ignored    = 0;
        n_bytes_rx   = 0;
        n_nacks      = 0;
        rnd_done     = 0;

        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.action      = ACT_TICK;
        in_bus.sda_in      = 1'b0;
        in_bus.dev_addr    = '0;
        in_bus.reg_addr    = '0;
        in_bus.data_first  = '0;
        in_bus.data_second = '0;
        in_bus.byte_count  = '0;

        ph     = BUS_IDLE;
        st     = '0;
        wr_ofs = '0;
        wr_tot = '0;
        rd_ofs = '0;
        rd_tot = '0;
        shreg  = '0;
        scl_q  = 1'b1;
        sda_q  = 1'b1;
        foreach (tx_store[k])
            tx_store[k] = '0;

        // action, sda, dev, reg, data0, data1, count, repeat, random sda, typed, line
        // idle bus: tick and the undefined action leave the lines released
        plan.push_back(mk_row(ACT_TICK, 0, 7'h00, 8'h00, 8'h00, 8'h00, 0, 1, 0, 1, LINE_IDLE));
        plan.push_back(mk_row(ACT_RSVD, 1, 7'h7f, 8'hff, 8'hff, 8'hff, 7, 1, 0, 1, LINE_IDLE));
        // write, count above two, data1 zero, rest all-ones; requests and junk while busy
        plan.push_back(mk_row(ACT_WRITE, 0, 7'h7f, 8'hff, 8'hff, 8'h00, 7, 1, 0, 1,
                              LINE_LOADED));
        plan.push_back(mk_row(ACT_TICK, 0, 7'h00, 8'h00, 8'h00, 8'h00, 0, 5, 0, 0, LINE_NONE));
        plan.push_back(mk_row(ACT_READ, 1, 7'h00, 8'h00, 8'h00, 8'h00, 7, 1, 0, 0, LINE_NONE));
        plan.push_back(mk_row(ACT_RSVD, 0, 7'h00, 8'h00, 8'h00, 8'h00, 0, 1, 0, 0, LINE_NONE));
        plan.push_back(mk_row(ACT_TICK, 0, 7'h00, 8'h00, 8'h00, 8'h00, 0, RUN_OUT, 0, 0,
                              LINE_NONE));
        plan.push_back(mk_row(ACT_TICK, 1, 7'h7f, 8'hff, 8'hff, 8'hff, 7, 1, 0, 1, LINE_IDLE));
        // zero-length write, slave NACKs everything
        plan.push_back(mk_row(ACT_WRITE, 1, 7'h00, 8'h00, 8'h00, 8'hff, 0, 1, 0, 1,
                              LINE_LOADED));
        plan.push_back(mk_row(ACT_TICK, 1, 7'h00, 8'h00, 8'h00, 8'h00, 0, RUN_OUT, 0, 0,
                              LINE_NONE));
        // read above the limit, line held high: four 0xff bytes, index runs up to three
        plan.push_back(mk_row(ACT_READ, 0, 7'h55, 8'haa, 8'h00, 8'h00, 7, 1, 0, 1,
                              LINE_LOADED));
        plan.push_back(mk_row(ACT_TICK, 1, 7'h00, 8'h00, 8'h00, 8'h00, 0, RUN_OUT, 0, 0,
                              LINE_NONE));
        // zero-byte read: no repeated START
        plan.push_back(mk_row(ACT_READ, 0, 7'h01, 8'h80, 8'h00, 8'h00, 0, 1, 0, 1,
                              LINE_LOADED));
        plan.push_back(mk_row(ACT_TICK, 0, 7'h00, 8'h00, 8'h00, 8'h00, 0, RUN_OUT, 1, 0,
                              LINE_NONE));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[k]) begin
            w = plan[k];
            if (w.reps == RUN_OUT) begin
                while (ph != BUS_IDLE) begin
                    r = w.req;
                    if (w.rnd_sda)
                        r.sda_in = $urandom_range(1);
                    put_item(r, 1'b0, LINE_NONE);
                end
            end else begin
                repeat (w.reps) begin
                    r = w.req;
                    if (w.rnd_sda)
                        r.sda_in = $urandom_range(1);
                    put_item(r, w.typed, w.line);
                end
            end
        end

        // Random part: mostly whole transactions with random content; the rest is
        // requests during a transaction, undefined actions and idle ticks.
        while (rnd_done < RAND_ITEMS || ph != BUS_IDLE) begin
            if (ph == BUS_IDLE) begin
                if ($urandom_range(99) < 85) begin
                    put_item(rand_req($urandom_range(1) ? ACT_WRITE : ACT_READ), 1'b0,
                             LINE_NONE);
                    rnd_done++;
                end else begin
                    put_item(rand_req($urandom_range(1) ? ACT_RSVD : ACT_TICK), 1'b0,
                             LINE_NONE);
                end
            end else if ($urandom_range(99) < 5) begin
                case ($urandom_range(2))
                    0:       r = rand_req(ACT_WRITE);
                    1:       r = rand_req(ACT_READ);
                    default: r = rand_req(ACT_RSVD);
                endcase
                put_item(r, 1'b0, LINE_NONE);
            end else begin
                put_item(rand_req(ACT_TICK), 1'b0, LINE_NONE);
                rnd_done++;
            end
        end

        @(negedge i_clk);
        in_bus.valid = 1'b0;
        while (pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("covered %0d input transfers: %0d writes, %0d reads, %0d ignored items",
                 in_accepted, n_writes, n_reads, n_ignored);
        $display("%0d results checked, %0d bytes read back, %0d slave NACKs, %0d mismatches",
                 results_seen, n_bytes_rx, n_nacks, mismatches);
        if (mismatches == 0) begin
            $display("i2c_bitbang_master verification clean");
        end else begin
            $display("i2c_bitbang_master verification failed");
        end
        $finish;
    end

endmodule
